// ===== rtl/core/lsei_pkg.sv =====
// shared types and constants for the line / screen edge crossing core
// no dependencies
package lsei_pkg;

  localparam int SIZE_BITS    = 12;
  localparam int POS_BITS     = 16;
  localparam int NUM_EDGES    = 4;
  localparam int FRONT_STAGES = 4;

  localparam int EDGE_LEFT   = 0;
  localparam int EDGE_RIGHT  = 1;
  localparam int EDGE_TOP    = 2;
  localparam int EDGE_BOTTOM = 3;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 12'd1024;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 12'd768;
  localparam logic [POS_BITS-1:0]  POS_MAX      = 16'hFFFF;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

endpackage

// ===== rtl/core/line_screen_edge_intersect_core.sv =====
// line / screen edge crossing core: four front stages, one divider stage per quotient bit,
// one output register
// throughput one request per cycle; stalls are absorbed stage by stage, so a
// request is taken while a result waits as long as a bubble is in the pipe
// rst_ni clears the valid bits and loads screen size 1024 x 768
module line_screen_edge_intersect_core #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  lsei_pkg::cfg_idx_e                   cfg_idx_i,
  input  logic [lsei_pkg::SIZE_BITS-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_BITS-1:0]         first_x_i,
  input  logic signed [COORD_BITS-1:0]         first_y_i,
  input  logic signed [COORD_BITS-1:0]         second_x_i,
  input  logic signed [COORD_BITS-1:0]         second_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 left_hit_o,
  output logic [lsei_pkg::POS_BITS-1:0]        left_edge_y_o,
  output logic                                 right_hit_o,
  output logic [lsei_pkg::POS_BITS-1:0]        right_edge_y_o,
  output logic                                 top_hit_o,
  output logic [lsei_pkg::POS_BITS-1:0]        top_edge_x_o,
  output logic                                 bottom_hit_o,
  output logic [lsei_pkg::POS_BITS-1:0]        bottom_edge_x_o
);
  import lsei_pkg::*;

  localparam int QB     = SIZE_BITS + FRAC_BITS;
  localparam int NNW    = SIZE_BITS + COORD_BITS + FRAC_BITS + 1;
  localparam int STAGES = FRONT_STAGES + QB + 1;
  localparam int QE     = (QB > POS_BITS) ? QB : POS_BITS;

  // screen size registers
  logic [SIZE_BITS-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
      endcase
    end
  end

  // valid bits and per-stage enables
  logic [STAGES-1:0] valid_q, valid_d, en;

  for (genvar k = 0; k < STAGES; k++) begin : g_en
    assign en[k] = out_ready_i | ~(&valid_q[STAGES-1:k]);
  end

  assign valid_d = {valid_q[STAGES-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[STAGES-1];

  // front end
  logic              f_hit [NUM_EDGES];
  logic [NNW-1:0]    f_num [NUM_EDGES];
  logic [COORD_BITS:0] f_div [NUM_EDGES];

  lsei_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .en_i     (en[FRONT_STAGES-1:0]),
    .x1_i     (first_x_i),
    .y1_i     (first_y_i),
    .x2_i     (second_x_i),
    .y2_i     (second_y_i),
    .width_i  (width_q),
    .height_i (height_q),
    .hit_o    (f_hit),
    .num_o    (f_num),
    .div_o    (f_div)
  );

  // divider lanes, one per edge
  logic          d_hit  [NUM_EDGES];
  logic [QB-1:0] d_quot [NUM_EDGES];

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_lane
    lsei_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (en[FRONT_STAGES +: QB]),
      .hit_i  (f_hit[e]),
      .num_i  (f_num[e]),
      .div_i  (f_div[e]),
      .hit_o  (d_hit[e]),
      .quot_o (d_quot[e])
    );
  end

  // output register: saturate, zero the position when there is no crossing
  logic                hit_q [NUM_EDGES];
  logic [POS_BITS-1:0] pos_q [NUM_EDGES];
  logic [POS_BITS-1:0] pos_d [NUM_EDGES];
  logic [QE-1:0]       quot_ext [NUM_EDGES];

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      quot_ext[e] = QE'(d_quot[e]);
      if (!d_hit[e]) begin
        pos_d[e] = '0;
      end else if (quot_ext[e] > QE'(POS_MAX)) begin
        pos_d[e] = POS_MAX;
      end else begin
        pos_d[e] = quot_ext[e][POS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[STAGES-1]) begin
      hit_q <= d_hit;
      pos_q <= pos_d;
    end
  end

  assign left_hit_o      = hit_q[EDGE_LEFT];
  assign left_edge_y_o   = pos_q[EDGE_LEFT];
  assign right_hit_o     = hit_q[EDGE_RIGHT];
  assign right_edge_y_o  = pos_q[EDGE_RIGHT];
  assign top_hit_o       = hit_q[EDGE_TOP];
  assign top_edge_x_o    = pos_q[EDGE_TOP];
  assign bottom_hit_o    = hit_q[EDGE_BOTTOM];
  assign bottom_edge_x_o = pos_q[EDGE_BOTTOM];

endmodule

// ===== rtl/core/lsei_front.sv =====
// front end: differences, products, crossing numerators and range test
// four register stages, builds dividend and divisor for the divider lanes
// depends on lsei_pkg
module lsei_front #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                                  clk_i,
  input  logic [lsei_pkg::FRONT_STAGES-1:0]                     en_i,
  input  logic signed [COORD_BITS-1:0]                          x1_i,
  input  logic signed [COORD_BITS-1:0]                          y1_i,
  input  logic signed [COORD_BITS-1:0]                          x2_i,
  input  logic signed [COORD_BITS-1:0]                          y2_i,
  input  logic [lsei_pkg::SIZE_BITS-1:0]                        width_i,
  input  logic [lsei_pkg::SIZE_BITS-1:0]                        height_i,
  output logic                                                  hit_o [lsei_pkg::NUM_EDGES],
  output logic [lsei_pkg::SIZE_BITS+COORD_BITS+FRAC_BITS:0]     num_o [lsei_pkg::NUM_EDGES],
  output logic [COORD_BITS:0]                                   div_o [lsei_pkg::NUM_EDGES]
);
  import lsei_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int AW  = ((C > SIZE_BITS + 1) ? C : SIZE_BITS + 1) + 1;
  localparam int PW  = 2 * C + 1;
  localparam int QW  = AW + C + 1;
  localparam int NW  = QW + 1;
  localparam int LW  = SIZE_BITS + C;
  localparam int NNW = LW + FRAC_BITS + 1;

  // stage 1: differences
  logic signed [C:0]      dx_p, dx_n, dy_p, dy_n;
  logic                   negx, negy;
  logic signed [C-1:0]    x1_q, y1_q;
  logic [C-1:0]           adx_d, ady_d, adx_q, ady_q;
  logic signed [C:0]      sdy_d, sdx_d, sdy_q, sdx_q;
  logic signed [AW-1:0]   wx_d, hy_d, wx_q, hy_q;
  logic                   zx_q, zy_q;
  logic [SIZE_BITS-1:0]   w1_q, h1_q;

  always_comb begin
    dx_p  = (C+1)'(x2_i) - (C+1)'(x1_i);
    dx_n  = (C+1)'(x1_i) - (C+1)'(x2_i);
    dy_p  = (C+1)'(y2_i) - (C+1)'(y1_i);
    dy_n  = (C+1)'(y1_i) - (C+1)'(y2_i);
    negx  = x2_i < x1_i;
    negy  = y2_i < y1_i;
    adx_d = negx ? dx_n[C-1:0] : dx_p[C-1:0];
    ady_d = negy ? dy_n[C-1:0] : dy_p[C-1:0];
    sdy_d = negx ? dy_n : dy_p;
    sdx_d = negy ? dx_n : dx_p;
    wx_d  = $signed(AW'({1'b0, width_i})) - AW'(x1_i);
    hy_d  = $signed(AW'({1'b0, height_i})) - AW'(y1_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x1_q  <= x1_i;
      y1_q  <= y1_i;
      adx_q <= adx_d;
      ady_q <= ady_d;
      sdy_q <= sdy_d;
      sdx_q <= sdx_d;
      wx_q  <= wx_d;
      hy_q  <= hy_d;
      zx_q  <= x1_i == x2_i;
      zy_q  <= y1_i == y2_i;
      w1_q  <= width_i;
      h1_q  <= height_i;
    end
  end

  // stage 2: products, sign of the denominator folded in
  logic signed [PW-1:0] a_d, b_d, e_d, f_d, a_q, b_q, e_q, f_q;
  logic signed [QW-1:0] c_d, g_d, c_q, g_q;
  logic [LW-1:0]        limh_d, limw_d, limh_q, limw_q;
  logic [C-1:0]         adx2_q, ady2_q;
  logic                 zx2_q, zy2_q;

  always_comb begin
    a_d    = PW'(y1_q) * PW'($signed({1'b0, adx_q}));
    b_d    = PW'(x1_q) * PW'(sdy_q);
    c_d    = QW'(wx_q) * QW'(sdy_q);
    e_d    = PW'(x1_q) * PW'($signed({1'b0, ady_q}));
    f_d    = PW'(y1_q) * PW'(sdx_q);
    g_d    = QW'(hy_q) * QW'(sdx_q);
    limh_d = LW'(h1_q) * LW'(adx_q);
    limw_d = LW'(w1_q) * LW'(ady_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
      e_q    <= e_d;
      f_q    <= f_d;
      g_q    <= g_d;
      limh_q <= limh_d;
      limw_q <= limw_d;
      adx2_q <= adx_q;
      ady2_q <= ady_q;
      zx2_q  <= zx_q;
      zy2_q  <= zy_q;
    end
  end

  // stage 3: numerators
  logic signed [NW-1:0] num3_d [NUM_EDGES];
  logic signed [NW-1:0] num3_q [NUM_EDGES];
  logic [LW-1:0]        limh3_q, limw3_q;
  logic [C-1:0]         adx3_q, ady3_q;
  logic                 zx3_q, zy3_q;

  always_comb begin
    num3_d[EDGE_LEFT]   = NW'(a_q) - NW'(b_q);
    num3_d[EDGE_RIGHT]  = NW'(a_q) + NW'(c_q);
    num3_d[EDGE_TOP]    = NW'(e_q) - NW'(f_q);
    num3_d[EDGE_BOTTOM] = NW'(e_q) + NW'(g_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      num3_q  <= num3_d;
      limh3_q <= limh_q;
      limw3_q <= limw_q;
      adx3_q  <= adx2_q;
      ady3_q  <= ady2_q;
      zx3_q   <= zx2_q;
      zy3_q   <= zy2_q;
    end
  end

  // stage 4: closed range test, dividend with rounding half added
  logic             hit4_d [NUM_EDGES];
  logic [NNW-1:0]   num4_d [NUM_EDGES];
  logic [C:0]       div4_d [NUM_EDGES];
  logic             hit4_q [NUM_EDGES];
  logic [NNW-1:0]   num4_q [NUM_EDGES];
  logic [C:0]       div4_q [NUM_EDGES];

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      hit4_d[e] = !((e <= EDGE_RIGHT) ? zx3_q : zy3_q) && !num3_q[e][NW-1] &&
                  ($unsigned(num3_q[e]) <= NW'((e <= EDGE_RIGHT) ? limh3_q : limw3_q));
      num4_d[e] = {num3_q[e][LW-1:0], {(FRAC_BITS+1){1'b0}}} +
                  NNW'((e <= EDGE_RIGHT) ? adx3_q : ady3_q);
      div4_d[e] = {((e <= EDGE_RIGHT) ? adx3_q : ady3_q), 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      hit4_q <= hit4_d;
      num4_q <= num4_d;
      div4_q <= div4_d;
    end
  end

  assign hit_o = hit4_q;
  assign num_o = num4_q;
  assign div_o = div4_q;

endmodule

// ===== rtl/core/lsei_div.sv =====
// pipelined restoring divider, one quotient bit per register stage
// quotient is known to fit SIZE_BITS+FRAC_BITS bits, depends on lsei_pkg
module lsei_div #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                               clk_i,
  input  logic [lsei_pkg::SIZE_BITS+FRAC_BITS-1:0]           en_i,
  input  logic                                               hit_i,
  input  logic [lsei_pkg::SIZE_BITS+COORD_BITS+FRAC_BITS:0]  num_i,
  input  logic [COORD_BITS:0]                                div_i,
  output logic                                               hit_o,
  output logic [lsei_pkg::SIZE_BITS+FRAC_BITS-1:0]           quot_o
);
  import lsei_pkg::*;

  localparam int QB  = SIZE_BITS + FRAC_BITS;
  localparam int RW  = COORD_BITS + 1;
  localparam int NNW = SIZE_BITS + COORD_BITS + FRAC_BITS + 1;

  logic [RW-1:0] r_q [QB-1];
  logic [RW-1:0] d_q [QB-1];
  logic [QB-1:0] s_q [QB];
  logic          h_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [RW-1:0] r_in, d_in;
    logic [QB-1:0] s_in;
    logic          h_in;
    logic [RW:0]   r_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = num_i[NNW-1:QB];
      assign s_in = num_i[QB-1:0];
      assign d_in = div_i;
      assign h_in = hit_i;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign s_in = s_q[k-1];
      assign d_in = d_q[k-1];
      assign h_in = h_q[k-1];
    end

    assign r_sh = {r_in, s_in[QB-1]};
    assign ge   = r_sh >= {1'b0, d_in};

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        s_q[k] <= {s_in[QB-2:0], ge};
        h_q[k] <= h_in;
      end
    end

    if (k < QB - 1) begin : g_rem
      logic [RW-1:0] r_d;
      assign r_d = ge ? RW'(r_sh - {1'b0, d_in}) : r_sh[RW-1:0];

      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          r_q[k] <= r_d;
          d_q[k] <= d_in;
        end
      end
    end
  end

  assign quot_o = s_q[QB-1];
  assign hit_o  = h_q[QB-1];

endmodule

// ===== rtl/core/lsei_checker.sv =====
// port-level checks for the line / screen edge crossing core
// bound to line_screen_edge_intersect_core, depends on lsei_pkg
module lsei_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic signed [COORD_BITS-1:0]         first_x_i,
  input logic signed [COORD_BITS-1:0]         first_y_i,
  input logic signed [COORD_BITS-1:0]         second_x_i,
  input logic signed [COORD_BITS-1:0]         second_y_i,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic                                 left_hit_o,
  input logic [lsei_pkg::POS_BITS-1:0]        left_edge_y_o,
  input logic                                 right_hit_o,
  input logic [lsei_pkg::POS_BITS-1:0]        right_edge_y_o,
  input logic                                 top_hit_o,
  input logic [lsei_pkg::POS_BITS-1:0]        top_edge_x_o,
  input logic                                 bottom_hit_o,
  input logic [lsei_pkg::POS_BITS-1:0]        bottom_edge_x_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(first_x_i) && $stable(first_y_i) &&
      $stable(second_x_i) && $stable(second_y_i))
    else $error("request withdrawn or changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(left_hit_o) && $stable(left_edge_y_o) &&
      $stable(right_hit_o) && $stable(right_edge_y_o) &&
      $stable(top_hit_o) && $stable(top_edge_x_o) &&
      $stable(bottom_hit_o) && $stable(bottom_edge_x_o))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (left_hit_o || left_edge_y_o == '0) && (right_hit_o || right_edge_y_o == '0) &&
      (top_hit_o || top_edge_x_o == '0) && (bottom_hit_o || bottom_edge_x_o == '0))
    else $error("position not zero on a miss");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("request refused with a free output");

endmodule

bind line_screen_edge_intersect_core lsei_checker #(
  .COORD_BITS (COORD_BITS)
) u_lsei_checker (.*);

// ===== dv/tb.sv =====
// testbench for line_screen_edge_intersect_core: line requests go through a queued driver,
// and a clocked monitor checks each result against an in-bench crossing predictor
// depends on rtl/core/lsei_pkg.sv and rtl/core/line_screen_edge_intersect_core.sv
`timescale 1ns / 1ps

module tb;
  import lsei_pkg::*;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 4;
  localparam int N_RANDOM     = 1950;
  localparam int N_PHASES     = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_SEND_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
  } line_t;

  typedef struct packed {
    logic [NUM_EDGES-1:0]               hit;
    logic [NUM_EDGES-1:0][POS_BITS-1:0] pos;
  } crossing_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  cfg_idx_e               cfg_idx_i   = CFG_WIDTH;
  logic [SIZE_BITS-1:0]   cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic signed [COORD_BITS-1:0] first_x_i  = '0;
  logic signed [COORD_BITS-1:0] first_y_i  = '0;
  logic signed [COORD_BITS-1:0] second_x_i = '0;
  logic signed [COORD_BITS-1:0] second_y_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   left_hit_o;
  logic [POS_BITS-1:0]    left_edge_y_o;
  logic                   right_hit_o;
  logic [POS_BITS-1:0]    right_edge_y_o;
  logic                   top_hit_o;
  logic [POS_BITS-1:0]    top_edge_x_o;
  logic                   bottom_hit_o;
  logic [POS_BITS-1:0]    bottom_edge_x_o;

  line_t                  pending_lines[$];
  crossing_t              awaited_crossings[$];
  logic [SIZE_BITS-1:0]   screen_w = WIDTH_RESET;
  logic [SIZE_BITS-1:0]   screen_h = HEIGHT_RESET;
  idle_mode_e             idle_mode = IDLE_SEND_LIGHT;
  logic                   in_taken = 1'b0;
  logic                   hold_done = 1'b0;
  int                     hold_left = 0;
  int                     n_queued = 0;
  int                     n_taken = 0;
  int                     n_errors = 0;

  string hit_name[NUM_EDGES] = '{"left_hit", "right_hit", "top_hit", "bottom_hit"};
  string pos_name[NUM_EDGES] = '{"left_edge_y", "right_edge_y", "top_edge_x", "bottom_edge_x"};

  line_screen_edge_intersect_core #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .first_x_i      (first_x_i),
    .first_y_i      (first_y_i),
    .second_x_i     (second_x_i),
    .second_y_i     (second_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_hit_o     (left_hit_o),
    .left_edge_y_o  (left_edge_y_o),
    .right_hit_o    (right_hit_o),
    .right_edge_y_o (right_edge_y_o),
    .top_hit_o      (top_hit_o),
    .top_edge_x_o   (top_edge_x_o),
    .bottom_hit_o   (bottom_hit_o),
    .bottom_edge_x_o(bottom_edge_x_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // crossing at num/den along an edge of length limit, rounded half up
  function automatic void edge_crossing(input longint num, input longint den,
                                        input longint limit, output logic hit,
                                        output logic [POS_BITS-1:0] pos);
    longint q;
    hit = 1'b0;
    pos = '0;
    if (den == 0) return;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0 || num > limit * den) return;
    q = ((num <<< (FRAC_BITS + 1)) + den) / (2 * den);
    if (q > longint'(POS_MAX)) q = longint'(POS_MAX);
    hit = 1'b1;
    pos = q[POS_BITS-1:0];
  endfunction

  function automatic crossing_t predict_crossings(line_t ln);
    longint    x1, y1, dx, dy, w, h;
    crossing_t r;
    x1 = ln.first_x;
    y1 = ln.first_y;
    dx = longint'(ln.second_x) - x1;
    dy = longint'(ln.second_y) - y1;
    w  = longint'(screen_w);
    h  = longint'(screen_h);
    edge_crossing(y1 * dx - x1 * dy, dx, h, r.hit[EDGE_LEFT], r.pos[EDGE_LEFT]);
    edge_crossing(y1 * dx + (w - x1) * dy, dx, h, r.hit[EDGE_RIGHT], r.pos[EDGE_RIGHT]);
    edge_crossing(x1 * dy - y1 * dx, dy, w, r.hit[EDGE_TOP], r.pos[EDGE_TOP]);
    edge_crossing(x1 * dy + (h - y1) * dx, dy, w, r.hit[EDGE_BOTTOM], r.pos[EDGE_BOTTOM]);
    return r;
  endfunction

  function automatic void compare_crossing(crossing_t want, crossing_t got);
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (got.hit[e] !== want.hit[e]) begin
        $error("%s: expected %0d, got %0d", hit_name[e], want.hit[e], got.hit[e]);
        n_errors++;
      end
      if (got.pos[e] !== want.pos[e]) begin
        $error("%s: expected %0d, got %0d", pos_name[e], want.pos[e], got.pos[e]);
        n_errors++;
      end
    end
  endfunction

  // driver: new request only once the previous one has been taken
  always @(negedge clk_i) begin
    line_t ln;
    int    send_idle;
    send_idle = (idle_mode == IDLE_SEND_LIGHT) ? 29 : (idle_mode == IDLE_SEND_HEAVY) ? 73 : 0;
    if (!in_valid_i || in_taken) begin
      if (pending_lines.size() > 0 && $urandom_range(99) >= send_idle) begin
        ln = pending_lines.pop_front();
        first_x_i  <= ln.first_x;
        first_y_i  <= ln.first_y;
        second_x_i <= ln.second_x;
        second_y_i <= ln.second_y;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off when idling stops
  always @(negedge clk_i) begin
    int recv_idle;
    recv_idle = (idle_mode == IDLE_SEND_LIGHT) ? 73 : (idle_mode == IDLE_SEND_HEAVY) ? 29 : 0;
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (idle_mode == IDLE_NONE && !hold_done) begin
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    line_t     ln;
    crossing_t got;
    crossing_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        ln.first_x  = first_x_i;
        ln.first_y  = first_y_i;
        ln.second_x = second_x_i;
        ln.second_y = second_y_i;
        awaited_crossings.insert(awaited_crossings.size(), predict_crossings(ln));
        n_taken++;
      end
      if (out_valid_o && out_ready_i) begin
        got.hit[EDGE_LEFT]   = left_hit_o;
        got.pos[EDGE_LEFT]   = left_edge_y_o;
        got.hit[EDGE_RIGHT]  = right_hit_o;
        got.pos[EDGE_RIGHT]  = right_edge_y_o;
        got.hit[EDGE_TOP]    = top_hit_o;
        got.pos[EDGE_TOP]    = top_edge_x_o;
        got.hit[EDGE_BOTTOM] = bottom_hit_o;
        got.pos[EDGE_BOTTOM] = bottom_edge_x_o;
        if (awaited_crossings.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          want = awaited_crossings.pop_front();
          compare_crossing(want, got);
        end
      end
    end
  end

  task automatic add_line(int x1, int y1, int x2, int y2);
    line_t ln;
    ln.first_x  = 16'(x1);
    ln.first_y  = 16'(y1);
    ln.second_x = 16'(x2);
    ln.second_y = 16'(y2);
    pending_lines.insert(pending_lines.size(), ln);
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_taken != n_queued || in_valid_i || awaited_crossings.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_screen(int w, int h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WIDTH;
    cfg_data_i <= SIZE_BITS'(w);
    @(negedge clk_i);
    cfg_idx_i  <= CFG_HEIGHT;
    cfg_data_i <= SIZE_BITS'(h);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    screen_w = SIZE_BITS'(w);
    screen_h = SIZE_BITS'(h);
    @(negedge clk_i);
  endtask

  // coordinate in [-len, 2*len], around and across the screen
  function automatic int around(int len);
    return int'($urandom_range(3 * len)) - len;
  endfunction

  task automatic add_random_line();
    int      w, h, kind, x1, y1, x2, y2, side;
    logic [31:0] rnd;
    w    = screen_w;
    h    = screen_h;
    kind = $urandom_range(99);
    x1 = around(w);
    y1 = around(h);
    x2 = around(w);
    y2 = around(h);
    if (kind < 50) begin
      // general line near the screen
    end else if (kind < 60) begin
      x2 = x1;
    end else if (kind < 70) begin
      y2 = y1;
    end else if (kind < 75) begin
      x2 = x1;
      y2 = y1;
    end else if (kind < 85) begin
      // both points on the border, crossings land at those points
      for (int p = 0; p < 2; p++) begin
        side = $urandom_range(3);
        case (side)
          0: begin x1 = 0; y1 = $urandom_range(h); end
          1: begin x1 = w; y1 = $urandom_range(h); end
          2: begin x1 = $urandom_range(w); y1 = 0; end
          default: begin x1 = $urandom_range(w); y1 = h; end
        endcase
        if (p == 0) begin
          x2 = x1;
          y2 = y1;
        end
      end
    end else begin
      rnd = $urandom(); x1 = int'(signed'(rnd[15:0]));
      rnd = $urandom(); y1 = int'(signed'(rnd[15:0]));
      rnd = $urandom(); x2 = int'(signed'(rnd[15:0]));
      rnd = $urandom(); y2 = int'(signed'(rnd[15:0]));
    end
    add_line(x1, y1, x2, y2);
  endtask

  initial begin
    int ws[N_PHASES];
    int hs[N_PHASES];
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed lines at the reset screen size
    add_line(-32768, -32768, 32767, 32767);
    add_line(32767, -32768, -32768, 32767);
    add_line(-32768, 32767, 32767, -32768);
    add_line(32767, 32767, -32768, -32768);
    add_line(0, 0, 0, 0);
    add_line(-32768, -32768, -32768, -32768);
    add_line(100, 200, 100, 200);
    add_line(0, -5, 0, 900);
    add_line(1024, 3, 1024, 50);
    add_line(500, -32768, 500, 32767);
    add_line(-7, 0, 2000, 0);
    add_line(3, 768, 40, 768);
    add_line(0, 0, 1024, 768);
    add_line(0, 768, 1024, 0);
    add_line(-1024, -768, 2048, 1536);
    add_line(31, 1, 63, 2);
    add_line(1, 31, 2, 63);
    add_line(0, 383, 1024, 384);
    add_line(-32768, 0, 32767, 1);
    add_line(1025, 0, 1025, 768);
    add_line(0, 769, 1, 769);
    add_line(-1, -1, 1, 1);
    wait_idle();

    ws = '{4095, 1, 1, 4095, 0, 0, 0, 640};
    hs = '{4095, 1, 4095, 1, 0, 0, 0, 480};
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ws[ph] == 0) ws[ph] = $urandom_range(4095, 1);
      if (hs[ph] == 0) hs[ph] = $urandom_range(4095, 1);
      idle_mode = (ph < 3) ? IDLE_SEND_LIGHT : (ph < 6) ? IDLE_SEND_HEAVY : IDLE_NONE;
      write_screen(ws[ph], hs[ph]);
      for (int i = 0; i < N_RANDOM / N_PHASES; i++) add_random_line();
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("line_screen_edge_intersect_core: match");
    end else begin
      $display("line_screen_edge_intersect_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("line_screen_edge_intersect_core: mismatch");
    $finish;
  end

endmodule
